### hw/rtl/aav_pkg.sv
package aav_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_END_WIN = 2'd1,
    KIND_END_PER = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMUL,
    ST_SDIV,
    ST_SNEXT,
    ST_WMUL1,
    ST_WMUL2,
    ST_WACC,
    ST_WDIV,
    ST_WSTORE,
    ST_PSUM,
    ST_PDIV,
    ST_OUT
  } state_e;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ActW = 16;
  localparam int unsigned TotalW = 48;

endpackage

### hw/rtl/accel_activity_variance_core.sv
// A sample is processed per axis in SMUL, SDIV and SNEXT, the division done by a
//   64-step restoring divider shared by the running means, the window division and the average.
// End window runs WMUL1, WMUL2 and WACC per axis, then WDIV and WSTORE (only WSTORE with no
//   samples); end period sums the slots in PSUM, divides in PDIV, sets m_axis_tvalid in OUT.
// One request is processed at a time; s_axis_tready is low while busy or a result waits.
// Reset (asynchronous, active low) clears sums, means, count and slot fill.
module accel_activity_variance_core #(
  parameter int unsigned WINDOW_SLOTS = 6,
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  input  logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] activity
  output logic [15:0] m_axis_tdata
);
  import aav_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned FillW = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned SlotW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned SumW = SampleW + CntW;
  localparam int unsigned SqW = 2 * SampleW + CntW;
  localparam int unsigned WinW = SqW + 2;
  localparam int unsigned PSumW = WinW + FillW;
  localparam int unsigned DivW = 64;
  localparam int unsigned DivCntW = 7;

  state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic signed [SampleW-1:0] samp_q [3];
  logic signed [SumW-1:0] sum_q [3];
  logic [SqW-1:0] sq_q [3];
  logic signed [SampleW-1:0] mean_q [3];
  logic [CntW-1:0] cnt_q;
  logic [WinW-1:0] win_q [WINDOW_SLOTS];
  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] pidx_q;
  logic signed [TotalW+16:0] tot_q;
  logic signed [TotalW+16:0] prod_q;
  logic [PSumW-1:0] psum_q;
  logic [ActW-1:0] out_q;
  logic out_v_q;

  // shared serial divider: magnitude restoring, sign fixed at end
  logic [DivW-1:0] dq_q, dr_q, dd_q;
  logic [DivCntW-1:0] dcnt_q;
  logic dneg_q;
  logic [DivW:0] rtrial;
  logic ddone;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;
  assign rtrial = {dr_q, dq_q[DivW-1]} - {1'b0, dd_q};
  assign ddone = (dcnt_q == '0);

  logic signed [SampleW-1:0] cur_mean;
  logic signed [SampleW-1:0] cur_samp;
  assign cur_mean = mean_q[axis_q];
  assign cur_samp = samp_q[axis_q];

  logic signed [SumW+SampleW:0] num_s;
  assign num_s = cur_mean * $signed({1'b0, cnt_q}) + cur_samp;

  logic signed [2*SampleW-1:0] samp_sq;
  logic signed [2*SampleW-1:0] mean_sq;
  logic signed [2*SampleW+CntW+1:0] mean_sq_n;
  logic signed [SampleW+SumW-1:0] mean_sum;
  assign samp_sq = cur_samp * cur_samp;
  assign mean_sq = cur_mean * cur_mean;
  assign mean_sq_n = $signed(prod_q[2*SampleW:0]) * $signed({1'b0, cnt_q});
  assign mean_sum = cur_mean * sum_q[axis_q];

  // next state
  always_comb begin
    state_d = state_q;
    axis_d = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        axis_d = '0;
        if (s_acc) begin
          unique case (kind_e'(s_axis_tuser))
            KIND_SAMPLE: state_d = (cnt_q >= CntW'(MAX_SAMPLES)) ? ST_IDLE : ST_SMUL;
            KIND_END_WIN: state_d = (fill_q >= FillW'(WINDOW_SLOTS)) ? ST_IDLE :
                                    (cnt_q == '0) ? ST_WSTORE : ST_WMUL1;
            KIND_END_PER: state_d = ST_PSUM;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SMUL: state_d = ST_SDIV;
      ST_SDIV: if (ddone) state_d = ST_SNEXT;
      ST_SNEXT: begin
        axis_d = axis_q + 2'd1;
        state_d = (axis_q == 2'd2) ? ST_IDLE : ST_SMUL;
      end
      ST_WMUL1: state_d = ST_WMUL2;
      ST_WMUL2: state_d = ST_WACC;
      ST_WACC: begin
        axis_d = axis_q + 2'd1;
        state_d = (axis_q == 2'd2) ? ST_WDIV : ST_WMUL1;
      end
      ST_WDIV: if (ddone && dneg_q) state_d = ST_WSTORE;
      ST_WSTORE: state_d = ST_IDLE;
      ST_PSUM: if (pidx_q >= fill_q) state_d = ST_PDIV;
      ST_PDIV: if (ddone) state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q <= '0;
      cnt_q <= '0;
      fill_q <= '0;
      pidx_q <= '0;
      out_v_q <= 1'b0;
      dcnt_q <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
        sq_q[i] <= '0;
        mean_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      axis_q <= axis_d;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 1'b1;
        if (!rtrial[DivW]) begin
          dr_q <= rtrial[DivW-1:0];
          dq_q <= {dq_q[DivW-2:0], 1'b1};
        end else begin
          dr_q <= {dr_q[DivW-2:0], dq_q[DivW-1]};
          dq_q <= {dq_q[DivW-2:0], 1'b0};
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          pidx_q <= '0;
          psum_q <= '0;
          tot_q <= '0;
          if (s_acc) begin
            for (int i = 0; i < 3; i++)
              samp_q[i] <= s_axis_tdata[i*SampleW +: SampleW];
            if (kind_e'(s_axis_tuser) == KIND_CLEAR) begin
              cnt_q <= '0;
              for (int i = 0; i < 3; i++) begin
                sum_q[i] <= '0;
                sq_q[i] <= '0;
                mean_q[i] <= '0;
              end
            end
          end
        end
        ST_SMUL: begin
          sum_q[axis_q] <= sum_q[axis_q] + SumW'(cur_samp);
          sq_q[axis_q] <= sq_q[axis_q] + SqW'($unsigned(samp_sq));
          dneg_q <= num_s[SumW+SampleW];
          dq_q <= DivW'(num_s[SumW+SampleW] ? -num_s : num_s);
          dr_q <= '0;
          dd_q <= DivW'(cnt_q) + 1'b1;
          dcnt_q <= DivCntW'(DivW);
        end
        ST_SDIV: if (ddone) mean_q[axis_q] <= SampleW'(dneg_q ? -dq_q : dq_q);
        ST_SNEXT: if (axis_q == 2'd2) cnt_q <= cnt_q + 1'b1;
        ST_WMUL1: prod_q <= (TotalW+17)'(mean_sq);
        ST_WMUL2: prod_q <= (TotalW+17)'(mean_sq_n);
        ST_WACC: begin
          tot_q <= tot_q + $signed({1'b0, sq_q[axis_q]}) + prod_q
                   - ((TotalW+17)'(mean_sum) <<< 1);
          dneg_q <= 1'b0;
        end
        ST_WDIV: begin
          if (dcnt_q == '0 && !dneg_q) begin
            dq_q <= tot_q[TotalW+16] ? '0 : DivW'(tot_q);
            dr_q <= '0;
            dd_q <= DivW'(cnt_q);
            dcnt_q <= DivCntW'(DivW);
            dneg_q <= 1'b1;
          end
        end
        ST_WSTORE: begin
          win_q[fill_q[SlotW-1:0]] <= (cnt_q == '0) ? '0 : WinW'(dq_q);
          fill_q <= fill_q + 1'b1;
          dneg_q <= 1'b0;
        end
        ST_PSUM: begin
          if (pidx_q < fill_q) begin
            psum_q <= psum_q + PSumW'(win_q[pidx_q[SlotW-1:0]]);
            pidx_q <= pidx_q + 1'b1;
          end else begin
            dq_q <= DivW'(psum_q);
            dr_q <= '0;
            dd_q <= (fill_q == '0) ? DivW'(1) : DivW'(fill_q);
            dcnt_q <= DivCntW'(DivW);
          end
        end
        ST_PDIV: ;
        ST_OUT: begin
          fill_q <= '0;
          out_q <= ((dq_q >> 4) > DivW'(16'hFFFF)) ? 16'hFFFF : dq_q[ActW+3:4];
          out_v_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // WDIV first cycle only loads the divider (dneg_q marks loaded)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready |=> out_v_q && $stable(out_q))
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW_SLOTS))
    else $error("slot overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_SAMPLES))
    else $error("count overflow");

endmodule

### bench/activity_checker.sv
module activity_checker #(
  parameter int unsigned WINDOW_SLOTS = 6,
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  input  logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] activity
  input  logic [15:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  import aav_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  longint      sum_q  [3];
  longint      sqsum_q[3];
  longint      mean_q [3];
  longint      n_q;
  longint      slot_q [WINDOW_SLOTS];
  int unsigned fill_q;

  logic [ActW-1:0] activity_q[$];

  assign pending_o = activity_q.size();

  task automatic clear_axes();
    for (int a = 0; a < 3; a++) begin
      sum_q[a]   = 0;
      sqsum_q[a] = 0;
      mean_q[a]  = 0;
    end
    n_q = 0;
  endtask

  task automatic predict_request(input kind_e kind, input logic [47:0] data);
    longint x;
    longint total;
    longint acc;
    case (kind)
      KIND_SAMPLE: begin
        // sample dropped once the count has saturated
        if (n_q < MAX_SAMPLES) begin
          for (int a = 0; a < 3; a++) begin
            x = longint'($signed(data[16*a +: 16]));
            sum_q[a]   += x;
            sqsum_q[a] += x * x;
            mean_q[a]  = (mean_q[a] * n_q + x) / (n_q + 1);
          end
          n_q++;
        end
      end
      KIND_END_WIN: begin
        if (fill_q < WINDOW_SLOTS) begin
          acc = 0;
          if (n_q != 0) begin
            total = 0;
            for (int a = 0; a < 3; a++)
              total += sqsum_q[a] + mean_q[a] * mean_q[a] * n_q - 2 * mean_q[a] * sum_q[a];
            if (total < 0) total = 0;
            acc = total / n_q;
          end
          slot_q[fill_q] = acc;
          fill_q++;
        end
      end
      KIND_END_PER: begin
        acc = 0;
        for (int s = 0; s < fill_q; s++) acc += slot_q[s];
        if (fill_q != 0) acc = acc / fill_q;
        acc = acc >>> 4;
        if (acc > 65535) acc = 65535;
        activity_q.push_back(acc[ActW-1:0]);
        fill_q = 0;
      end
      default: clear_axes();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o = 0;
      fill_q = 0;
      clear_axes();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (activity_q.size() == 0) begin
          $display("%0t: unexpected activity result, expected none, actual %0d",
                   $time, m_axis_tdata);
          fail_count_o++;
        end else begin
          if (m_axis_tdata !== activity_q[0]) begin
            $display("%0t: activity mismatch, expected %0d, actual %0d",
                     $time, activity_q[0], m_axis_tdata);
            fail_count_o++;
          end
          void'(activity_q.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_request(kind_e'(s_axis_tuser), s_axis_tdata);
    end
  end
endmodule

### bench/tb_top.sv
module tb_top;
  import aav_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 3_000_000;
  // small sample limit so that saturation is reached with few requests
  localparam int unsigned MaxSamples = 32;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  logic [47:0] s_axis_tdata;
  // [1:0] kind
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] activity
  logic [15:0] m_axis_tdata;

  int     fail_count;
  int     pending;
  int     tx_idle;
  int     rx_idle;
  int     hold_cycles;
  longint cycle_cnt;

  accel_activity_variance_core #(
    .MAX_SAMPLES(MaxSamples)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  activity_checker #(
    .MAX_SAMPLES(MaxSamples)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off when requested
  initial begin
    int held;
    bit hold_done;
    held = 0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0 && !hold_done && held < hold_cycles) begin
        held++;
        m_axis_tready <= 1'b0;
      end else begin
        if (hold_cycles > 0) hold_done = 1'b1;
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'(int'($urandom_range(16)) - 8);
      3:       return $urandom_range(1) ? 16'(16'h8000 + $urandom_range(255))
                                        : 16'(16'h7fff - $urandom_range(255));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send(input kind_e kind, input logic [15:0] x, input logic [15:0] y,
                      input logic [15:0] z);
    if ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_sample();
    send(KIND_SAMPLE, pick_axis(), pick_axis(), pick_axis());
  endtask

  task automatic send_ctrl(input kind_e kind);
    send(kind, 16'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  task automatic random_traffic(input int items);
    int sent;
    int windows;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 85) begin
        windows = $urandom_range(7);
        for (int w = 0; w < windows; w++) begin
          if ($urandom_range(9) == 0) begin
            send_ctrl(KIND_CLEAR);
            sent++;
          end
          repeat ($urandom_range(6)) begin
            send_sample();
            sent++;
          end
          send_ctrl(KIND_END_WIN);
          sent++;
        end
        send_ctrl(KIND_END_PER);
        sent++;
      end else begin
        send(kind_e'($urandom_range(3)), 16'($urandom()), 16'($urandom()),
             16'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_SAMPLE;
    tx_idle       = 34;
    rx_idle       = 57;
    hold_cycles   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty period, empty window, then extremes
    send_ctrl(KIND_END_PER);
    send_ctrl(KIND_END_WIN);
    send_ctrl(KIND_END_PER);
    send(KIND_SAMPLE, 16'h8000, 16'h7fff, 16'h0000);
    send(KIND_SAMPLE, 16'h7fff, 16'h8000, 16'hffff);
    send(KIND_SAMPLE, 16'h8000, 16'h7fff, 16'h0001);
    send(KIND_SAMPLE, 16'h7fff, 16'h8000, 16'h8000);
    send_ctrl(KIND_END_WIN);
    send_ctrl(KIND_END_PER);
    // slots full: seven windows, the last one dropped
    send_ctrl(KIND_CLEAR);
    send(KIND_SAMPLE, 16'h0003, 16'hfffd, 16'h0000);
    send(KIND_SAMPLE, 16'h0000, 16'h0004, 16'h7fff);
    repeat (7) send_ctrl(KIND_END_WIN);
    send_ctrl(KIND_END_PER);
    send_ctrl(KIND_CLEAR);
    send_ctrl(KIND_END_WIN);
    send_ctrl(KIND_END_PER);

    // receiver stalls for a long stretch while requests keep coming
    hold_cycles = 400;
    for (int p = 0; p < 4; p++) begin
      send_sample();
      send_ctrl(KIND_END_WIN);
      send_ctrl(KIND_END_PER);
    end
    random_traffic(120);

    // sender pauses until the block has drained
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    tx_idle = 57;
    rx_idle = 34;
    random_traffic(120);

    tx_idle = 0;
    rx_idle = 0;
    // count saturation: push past the sample limit
    send_ctrl(KIND_CLEAR);
    repeat (MaxSamples + 4) send_sample();
    send_ctrl(KIND_END_WIN);
    send_ctrl(KIND_END_PER);
    send_ctrl(KIND_CLEAR);
    random_traffic(120);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/aav_pkg.sv
hw/rtl/accel_activity_variance_core.sv
bench/activity_checker.sv
bench/tb_top.sv
